FILE: hdl/mpct_pkg.sv
// ============================================================================
// mpct_pkg: shared types and constants for the mouse packet cursor tracker
// Holds coordinate widths, register indexes, header bit positions and the
// structs passed between the top level and the cursor update logic.
// ============================================================================
package mpct_pkg;

    // Coordinate and field widths
    localparam int COORD_BITS = 12;
    localparam int OUT_BITS   = 12;
    localparam int DIM_BITS   = 13;
    localparam int BYTE_BITS  = 8;
    localparam int MOVE_BITS  = BYTE_BITS;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int CMP_BITS   = (DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS;

    localparam logic [COORD_BITS-1:0] COORD_MAX   = {COORD_BITS{1'b1}};
    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(384);

    // Configuration port
    localparam int REG_INDEX_BITS = 2;
    localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = REG_INDEX_BITS'(0);
    localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = REG_INDEX_BITS'(1);
    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(768);

    // Header byte bit positions
    localparam int HDR_LEFT_BIT   = 0;
    localparam int HDR_VALID_BIT  = 3;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    // Packet byte position, one-hot
    typedef enum logic [2:0] {
        ST_HEADER = 3'b001,
        ST_X_MOVE = 3'b010,
        ST_Y_MOVE = 3'b100
    } pkt_state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } screen_cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } cursor_pos_t;

endpackage

FILE: hdl/mpct_cursor_update.sv
// ============================================================================
// mpct_cursor_update: movement decode and clamped cursor arithmetic
// Forms 9-bit signed movements from a packet, halves them toward zero,
// applies them to the cursor and clamps both axes to the screen.
// ============================================================================
module mpct_cursor_update (
    input  logic [7:0]            header_byte,
    input  logic [7:0]            x_move_byte,
    input  logic [7:0]            y_move_byte,
    input  mpct_pkg::cursor_pos_t pos_cur,
    input  mpct_pkg::screen_cfg_t screen_cfg,
    output mpct_pkg::cursor_pos_t pos_new
);
    import mpct_pkg::*;

    // Halve a 9-bit signed movement, truncating toward zero
    function automatic logic signed [MOVE_BITS-1:0] half_move(
        input logic [BYTE_BITS-1:0] low_byte,
        input logic                 sign_bit
    );
        logic signed [BYTE_BITS:0] v;
        logic signed [BYTE_BITS:0] t;
        begin
            v = $signed({sign_bit, low_byte});
            t = v + $signed({{BYTE_BITS{1'b0}}, sign_bit});
            half_move = $signed(t[BYTE_BITS:1]);
        end
    endfunction

    // Clamp to [0, dim - 1], limit saturated at the coordinate range
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0] v,
        input logic [DIM_BITS-1:0]        dim
    );
        logic [CMP_BITS-1:0]   dim_m1;
        logic [COORD_BITS-1:0] limit;
        begin
            dim_m1 = CMP_BITS'(dim) - CMP_BITS'(1);
            if (dim == '0) begin
                limit = '0;
            end else if (dim_m1 > CMP_BITS'(COORD_MAX)) begin
                limit = COORD_MAX;
            end else begin
                limit = COORD_BITS'(dim_m1);
            end
            if (v[SUM_BITS-1]) begin
                clamp_coord = '0;
            end else if (v > $signed({2'b00, limit})) begin
                clamp_coord = limit;
            end else begin
                clamp_coord = v[COORD_BITS-1:0];
            end
        end
    endfunction

    logic signed [MOVE_BITS-1:0] dx;
    logic signed [MOVE_BITS-1:0] dy;
    logic signed [SUM_BITS-1:0]  x_sum;
    logic signed [SUM_BITS-1:0]  y_sum;

    // Decode movements
    assign dx = half_move(x_move_byte, header_byte[HDR_X_SIGN_BIT]);
    assign dy = half_move(y_move_byte, header_byte[HDR_Y_SIGN_BIT]);

    // Add X, subtract Y so that Y grows downward
    assign x_sum = $signed({2'b00, pos_cur.x}) + SUM_BITS'(dx);
    assign y_sum = $signed({2'b00, pos_cur.y}) - SUM_BITS'(dy);

    assign pos_new.x = clamp_coord(x_sum, screen_cfg.width);
    assign pos_new.y = clamp_coord(y_sum, screen_cfg.height);

endmodule

FILE: hdl/mouse_packet_cursor_tracker.sv
// ============================================================================
// mouse_packet_cursor_tracker: PS/2 mouse packet decoder and cursor tracker
// Groups auxiliary-port bytes into three-byte packets and emits the clamped
// cursor position and left-button state for each valid packet.
// ============================================================================
// A packet's third byte passes through the input register, then the result register, to m_valid.
// Throughput: one byte per cycle; one result per valid three-byte packet.
// The input register stalls only while a result waits and m_ready is low.
// Reset (aresetn low, synchronous): cursor to (512, 384), screen 1024 x 768,
// packet position to header, input and result registers empty.
module mouse_packet_cursor_tracker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [mpct_pkg::REG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mpct_pkg::DIM_BITS-1:0]          cfg_data,
    // Byte input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [7:0]                             s_data_byte,
    // Result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [11:0]                            m_cursor_x,
    output logic [11:0]                            m_cursor_y,
    output logic                                   m_left_pressed
);
    import mpct_pkg::*;

    screen_cfg_t              screen_cfg_reg;
    logic                     in_valid_reg;
    logic [BYTE_BITS-1:0]     in_byte_reg;
    pkt_state_t               state_reg;
    pkt_state_t               state_next;
    logic [BYTE_BITS-1:0]     header_reg;
    logic [BYTE_BITS-1:0]     x_move_reg;
    cursor_pos_t              pos_reg;
    cursor_pos_t              pos_next;
    logic                     out_valid_reg;
    logic                     left_reg;
    logic                     out_free;
    logic                     advance;
    logic                     emit;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_cfg_reg.width  <= SCREEN_WIDTH_RESET;
            screen_cfg_reg.height <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_cfg_reg.width  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_cfg_reg.height <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: advance the input register whenever the result slot is free
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Packet byte position; a stray code completes the packet
    always_comb begin
        state_next = state_reg;
        emit       = 1'b0;
        unique case (state_reg)
            ST_HEADER: state_next = ST_X_MOVE;
            ST_X_MOVE: state_next = ST_Y_MOVE;
            default: begin
                state_next = ST_HEADER;
                emit       = advance && header_reg[HDR_VALID_BIT];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HEADER;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Capture header and X movement bytes
    always_ff @(posedge aclk) begin
        if (advance && state_reg == ST_HEADER) begin
            header_reg <= in_byte_reg;
        end
        if (advance && state_reg == ST_X_MOVE) begin
            x_move_reg <= in_byte_reg;
        end
    end

    mpct_cursor_update u_cursor_update (
        .header_byte (header_reg),
        .x_move_byte (x_move_reg),
        .y_move_byte (in_byte_reg),
        .pos_cur     (pos_reg),
        .screen_cfg  (screen_cfg_reg),
        .pos_new     (pos_next)
    );

    // Cursor and result registers; drop packets without the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg.x     <= POS_X_RESET;
            pos_reg.y     <= POS_Y_RESET;
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            pos_reg       <= pos_next;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            left_reg <= header_reg[HDR_LEFT_BIT];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_cursor_x     = OUT_BITS'(pos_reg.x);
    assign m_cursor_y     = OUT_BITS'(pos_reg.y);
    assign m_left_pressed = left_reg;

endmodule

FILE: hdl/mpct_checker.sv
// ============================================================================
// mpct_checker: port-level checks for the mouse packet cursor tracker
// Watches reset, result timing and result channel stability on the ports.
// ============================================================================
module mpct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_cursor_x,
    input logic [11:0] m_cursor_y,
    input logic        m_left_pressed
);
    import mpct_pkg::*;

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A fresh result follows a byte transfer through the input and result registers
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(s_valid && s_ready, 2))
        else $error("result without byte transfer two cycles earlier");

    // Hold a stalled result
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            ($stable(m_cursor_x) && $stable(m_cursor_y) && $stable(m_left_pressed)))
        else $error("stalled result payload changed");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_cursor_x     (m_cursor_x),
    .m_cursor_y     (m_cursor_y),
    .m_left_pressed (m_left_pressed)
);
